FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the timer queue.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer queue check failed");

`endif

FILE: src/dtq_pkg.sv
// Package for the deadline timer queue: field widths, request and result codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;
	localparam int ID_W = 6;
	localparam int DL_W = 64;
	localparam int TAG_W = 32;
	localparam int NUM_TIMERS_DEF = 32;

	typedef enum logic [1:0] {
		REQ_REGISTER  = 2'd0,
		REQ_REMOVE    = 2'd1,
		REQ_INTERRUPT = 2'd2,
		REQ_UNUSED    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_REGISTER = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_EXPIRED  = 2'd2,
		KIND_INT_DONE = 2'd3
	} kind_t;
endpackage
`default_nettype wire

FILE: src/deadline_timer_queue_unit.sv
// Deadline timer queue: fixed pool of one-shot timers, ids 1..NUM_TIMERS.
// Register pops an id, sets its deadline, then runs a linear scan of the deadline
// memory (one read per cycle); each expiry of an interrupt costs a further scan.
// Remove answers in the cycle after acceptance; an unused code is dropped at once.
// Reset: no timer is live, the free stack holds all ids with id 1 on top.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module deadline_timer_queue_unit
	import dtq_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [DL_W-1:0]   delay,
	input  wire logic [DL_W-1:0]   now,
	input  wire logic [ID_W-1:0]   target_id,
	input  wire logic [TAG_W-1:0]  user_tag,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [1:0]             result_kind,
	output logic                   status,
	output logic [ID_W-1:0]        res_id,
	output logic [TAG_W-1:0]       expired_tag,
	output logic                   wake_valid,
	output logic [DL_W-1:0]        wake_time,
	output logic                   last
);
	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(NUM_TIMERS);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_POP    = 7'b0000010,
		ST_WRITE  = 7'b0000100,
		ST_SCAN   = 7'b0001000,
		ST_DRAIN  = 7'b0010000,
		ST_DECIDE = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t st_q;

	// State memories and their bookkeeping.
	logic [DL_W-1:0]  dl_mem [NUM_TIMERS];
	logic [TAG_W-1:0] tag_mem [NUM_TIMERS];
	logic [ID_W-1:0]  stk_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] stk_vld_q;
	logic [NUM_TIMERS-1:0] live_q;
	logic [CW-1:0]         free_cnt_q;

	// Request latched at acceptance.
	logic              is_int_q;
	logic [DL_W-1:0]   now_q;
	logic [DL_W-1:0]   delay_q;
	logic [TAG_W-1:0]  tag_q;
	logic [IW-1:0]     slot_q;
	logic              expired_any_q;
	logic              more_q;

	// Scan state.
	logic [IW-1:0]     idx_q;
	logic              cmp_v_s1;
	logic [IW-1:0]     idx_s1;
	logic [DL_W-1:0]   rd_dl_s1;
	logic [TAG_W-1:0]  rd_tag_s1;
	logic              have_q;
	logic [IW-1:0]     best_idx_q;
	logic [DL_W-1:0]   best_dl_q;
	logic [TAG_W-1:0]  best_tag_q;

	// Free stack read.
	logic [IW-1:0]     stk_idx_s1;
	logic              stk_vld_s1;
	logic [ID_W-1:0]   stk_rd_s1;
	logic [ID_W-1:0]   pop_id;

	logic              accept;
	logic              rm_ok;
	logic [IW-1:0]     rm_idx;

	assign req_stall = (st_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign rm_idx = IW'(target_id - ID_W'(1));
	assign rm_ok  = (target_id >= ID_W'(1)) && (target_id <= ID_W'(NUM_TIMERS))
		&& live_q[rm_idx];

	// An entry never pushed still holds its reset id.
	assign pop_id = stk_vld_s1 ? stk_rd_s1 : ID_W'(NUM_TIMERS - int'(stk_idx_s1));

	always_ff @(posedge clk) begin
		dl_mem_rd: begin
			rd_dl_s1  <= dl_mem[idx_q];
			rd_tag_s1 <= tag_mem[idx_q];
		end
		if (st_q == ST_WRITE) begin
			dl_mem[IW'(pop_id - ID_W'(1))]  <= now_q + delay_q;
			tag_mem[IW'(pop_id - ID_W'(1))] <= tag_q;
		end
	end

	always_ff @(posedge clk) begin
		// The top of the stack is captured while idle and held through the pop.
		if (st_q == ST_IDLE) begin
			stk_rd_s1 <= stk_mem[IW'(free_cnt_q - CW'(1))];
		end
		if (accept && req_type == REQ_REMOVE && rm_ok && free_cnt_q < FULL_CNT) begin
			stk_mem[free_cnt_q[IW-1:0]] <= target_id;
		end else if (st_q == ST_DECIDE && is_int_q && have_q && best_dl_q <= now_q
				&& free_cnt_q < FULL_CNT) begin
			stk_mem[free_cnt_q[IW-1:0]] <= ID_W'(best_idx_q) + ID_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			stk_vld_q     <= '0;
			live_q        <= '0;
			free_cnt_q    <= FULL_CNT;
			res_valid     <= 1'b0;
			cmp_v_s1      <= 1'b0;
			have_q        <= 1'b0;
			more_q        <= 1'b0;
			expired_any_q <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (cmp_v_s1 && live_q[idx_s1] && (!have_q || rd_dl_s1 < best_dl_q)) begin
				have_q     <= 1'b1;
				best_idx_q <= idx_s1;
				best_dl_q  <= rd_dl_s1;
				best_tag_q <= rd_tag_s1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						now_q         <= now;
						delay_q       <= delay;
						tag_q         <= user_tag;
						is_int_q      <= (req_type == REQ_INTERRUPT);
						expired_any_q <= 1'b0;
						idx_q         <= '0;
						have_q        <= 1'b0;
						more_q        <= 1'b0;
						expired_tag   <= '0;
						wake_valid    <= 1'b0;
						wake_time     <= '0;
						last          <= 1'b1;
						case (req_type)
							REQ_REGISTER: begin
								if (free_cnt_q == '0) begin
									result_kind <= KIND_REGISTER;
									status      <= 1'b1;
									res_id      <= '0;
									res_valid   <= 1'b1;
									st_q        <= ST_EMIT;
								end else begin
									stk_idx_s1 <= IW'(free_cnt_q - CW'(1));
									stk_vld_s1 <= stk_vld_q[IW'(free_cnt_q - CW'(1))];
									free_cnt_q <= free_cnt_q - CW'(1);
									st_q       <= ST_POP;
								end
							end
							REQ_REMOVE: begin
								result_kind <= KIND_REMOVE;
								status      <= !rm_ok;
								res_id      <= target_id;
								res_valid   <= 1'b1;
								st_q        <= ST_EMIT;
								if (rm_ok) begin
									live_q[rm_idx] <= 1'b0;
									if (free_cnt_q < FULL_CNT) begin
										stk_vld_q[free_cnt_q[IW-1:0]] <= 1'b1;
										free_cnt_q <= free_cnt_q + CW'(1);
									end
								end
							end
							REQ_INTERRUPT: st_q <= ST_SCAN;
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_POP: st_q <= ST_WRITE;
				ST_WRITE: begin
					if (pop_id < ID_W'(1) || pop_id > ID_W'(NUM_TIMERS)) begin
						result_kind <= KIND_REGISTER;
						status      <= 1'b1;
						res_id      <= '0;
						res_valid   <= 1'b1;
						st_q        <= ST_EMIT;
					end else begin
						slot_q                   <= IW'(pop_id - ID_W'(1));
						live_q[IW'(pop_id - ID_W'(1))] <= 1'b1;
						st_q                     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// One deadline read per cycle; the compare follows in the next cycle.
					cmp_v_s1 <= 1'b1;
					idx_s1   <= idx_q;
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						st_q  <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					cmp_v_s1 <= 1'b0;
					st_q     <= ST_DECIDE;
				end
				ST_DECIDE: begin
					res_valid <= 1'b1;
					st_q      <= ST_EMIT;
					more_q    <= 1'b0;
					if (!is_int_q) begin
						result_kind <= KIND_REGISTER;
						status      <= 1'b0;
						res_id      <= ID_W'(slot_q) + ID_W'(1);
						last        <= 1'b1;
						if (have_q && best_idx_q == slot_q) begin
							wake_valid <= 1'b1;
							wake_time  <= best_dl_q;
						end
					end else if (!have_q) begin
						result_kind <= KIND_INT_DONE;
						status      <= !expired_any_q;
						res_id      <= '0;
						expired_tag <= '0;
						wake_valid  <= 1'b0;
						wake_time   <= '0;
						last        <= 1'b1;
					end else if (best_dl_q <= now_q) begin
						result_kind   <= KIND_EXPIRED;
						status        <= 1'b0;
						res_id        <= ID_W'(best_idx_q) + ID_W'(1);
						expired_tag   <= best_tag_q;
						wake_valid    <= 1'b0;
						wake_time     <= '0;
						last          <= 1'b0;
						more_q        <= 1'b1;
						expired_any_q <= 1'b1;
						live_q[best_idx_q] <= 1'b0;
						if (free_cnt_q < FULL_CNT) begin
							stk_vld_q[free_cnt_q[IW-1:0]] <= 1'b1;
							free_cnt_q <= free_cnt_q + CW'(1);
						end
					end else begin
						result_kind <= KIND_INT_DONE;
						status      <= 1'b0;
						res_id      <= '0;
						expired_tag <= '0;
						wake_valid  <= 1'b1;
						wake_time   <= best_dl_q;
						last        <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (!res_stall) begin
						res_valid <= 1'b0;
						if (more_q) begin
							// Another expiry may be due: rescan from the first slot.
							have_q <= 1'b0;
							idx_q  <= '0;
							st_q   <= ST_SCAN;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`DTQ_ASSERT_IMP(a_res_in_emit, res_valid, st_q == ST_EMIT)
	`DTQ_ASSERT_IMP(a_pool_conserved, st_q == ST_IDLE,
		CW'($countones(live_q)) + free_cnt_q == FULL_CNT)
	`DTQ_ASSERT_NXT(a_beat_leaves, res_valid && !res_stall && last, st_q == ST_IDLE)
endmodule
`default_nettype wire

FILE: sim/deadline_timer_queue_unit_tb.sv
// Testbench for the deadline timer queue: a directed table, then random register,
// remove, interrupt, unused requests, all checked against a behavioral timer pool.
// Depends on dtq_pkg and deadline_timer_queue_unit.
`timescale 1ns / 1ps
module deadline_timer_queue_unit_tb;
	import dtq_pkg::*;

	localparam int NT = NUM_TIMERS_DEF;

	typedef struct packed {
		logic [1:0]  kind;
		logic        st;
		logic [5:0]  id;
		logic [31:0] tag;
		logic        wv;
		logic [63:0] wt;
		logic        lst;
	} outcome_t;

	typedef struct {
		req_t        rq;
		logic [63:0] dly;
		logic [63:0] tnow;
		logic [5:0]  tgt;
		logic [31:0] utag;
		bit          has_exp;
		outcome_t    exp_out;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = REQ_REGISTER;
	logic [63:0] delay = '0;
	logic [63:0] now = '0;
	logic [5:0] target_id = '0;
	logic [31:0] user_tag = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] result_kind;
	logic status;
	logic [5:0] res_id;
	logic [31:0] expired_tag;
	logic wake_valid;
	logic [63:0] wake_time;
	logic last;

	deadline_timer_queue_unit i_dut (.*);

	always #1 clk = ~clk;

	// Predicted timer pool.
	logic [63:0] pool_deadline [NT];
	logic [31:0] pool_tag [NT];
	bit pool_live [NT];
	logic [5:0] free_ids [NT];
	int free_top;

	outcome_t pending_outcomes [$];
	int errors = 0;
	bit quiet_end = 0;
	logic [5:0] live_list [$];

	function automatic int soonest_slot();
		int best;
		best = -1;
		for (int i = 0; i < NT; i++)
			if (pool_live[i] && (best < 0 || pool_deadline[i] < pool_deadline[best]))
				best = i;
		return best;
	endfunction

	function automatic outcome_t mk(logic [1:0] k, logic s, logic [5:0] i, logic [31:0] t,
			logic v, logic [63:0] w, logic l);
		outcome_t o;
		o.kind = k; o.st = s; o.id = i; o.tag = t; o.wv = v; o.wt = w; o.lst = l;
		return o;
	endfunction

	function automatic void free_slot(int s);
		pool_live[s] = 0;
		if (free_top < NT) begin
			free_ids[free_top] = 6'(s + 1);
			free_top++;
		end
	endfunction

	// Queues the results one request causes, in the order they leave the block.
	function automatic void predict_request(req_t rq, logic [63:0] dly, logic [63:0] tnow,
			logic [5:0] tgt, logic [31:0] utag);
		int s;
		logic [5:0] id;
		case (rq)
			REQ_REGISTER: begin
				if (free_top == 0) begin
					pending_outcomes.push_back(mk(KIND_REGISTER, 1, 0, 0, 0, 0, 1));
				end else begin
					free_top--;
					id = free_ids[free_top];
					s = id - 1;
					pool_deadline[s] = tnow + dly;
					pool_tag[s] = utag;
					pool_live[s] = 1;
					if (soonest_slot() == s)
						pending_outcomes.push_back(mk(KIND_REGISTER, 0, id, 0, 1,
							pool_deadline[s], 1));
					else
						pending_outcomes.push_back(mk(KIND_REGISTER, 0, id, 0, 0, 0, 1));
				end
			end
			REQ_REMOVE: begin
				if (tgt >= 1 && tgt <= NT && pool_live[tgt-1]) begin
					free_slot(tgt - 1);
					pending_outcomes.push_back(mk(KIND_REMOVE, 0, tgt, 0, 0, 0, 1));
				end else begin
					pending_outcomes.push_back(mk(KIND_REMOVE, 1, tgt, 0, 0, 0, 1));
				end
			end
			REQ_INTERRUPT: begin
				s = soonest_slot();
				if (s < 0) begin
					pending_outcomes.push_back(mk(KIND_INT_DONE, 1, 0, 0, 0, 0, 1));
				end else begin
					while (s >= 0 && pool_deadline[s] <= tnow) begin
						pending_outcomes.push_back(mk(KIND_EXPIRED, 0, 6'(s + 1),
							pool_tag[s], 0, 0, 0));
						free_slot(s);
						s = soonest_slot();
					end
					if (s >= 0)
						pending_outcomes.push_back(mk(KIND_INT_DONE, 0, 0, 0, 1,
							pool_deadline[s], 1));
					else
						pending_outcomes.push_back(mk(KIND_INT_DONE, 0, 0, 0, 0, 0, 1));
				end
			end
			default: ;
		endcase
	endfunction

	// Result checking.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result beat kind=%0d id=%0d", result_kind, res_id);
				errors++;
			end else begin
				e = pending_outcomes.pop_front();
				if (result_kind !== e.kind) begin
					$error("result_kind expected %0d actual %0d", e.kind, result_kind); errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status); errors++;
				end
				if (res_id !== e.id) begin
					$error("res_id expected %0d actual %0d", e.id, res_id); errors++;
				end
				if (expired_tag !== e.tag) begin
					$error("expired_tag expected %h actual %h", e.tag, expired_tag); errors++;
				end
				if (wake_valid !== e.wv) begin
					$error("wake_valid expected %0d actual %0d", e.wv, wake_valid); errors++;
				end
				if (wake_time !== e.wt) begin
					$error("wake_time expected %h actual %h", e.wt, wake_time); errors++;
				end
				if (last !== e.lst) begin
					$error("last expected %0d actual %0d", e.lst, last); errors++;
				end
			end
		end
	end

	// Receiver stalls in bursts, none near the end.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet_end && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 8);
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				res_stall <= 1'b0;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end
		end
	end

	// Valid stays high from one beat to the next unless an idle burst comes between.
	task automatic send_request(req_t rq, logic [63:0] dly, logic [63:0] tnow,
			logic [5:0] tgt, logic [31:0] utag);
		if (!quiet_end && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= rq;
		delay <= dly;
		now <= tnow;
		target_id <= tgt;
		user_tag <= utag;
		do @(posedge clk); while (req_stall);
		predict_request(rq, dly, tnow, tgt, utag);
	endtask

	row_t plan [$];

	function automatic row_t row(req_t rq, logic [63:0] dly, logic [63:0] tnow,
			logic [5:0] tgt, logic [31:0] utag, bit he, outcome_t eo);
		row_t r;
		r.rq = rq; r.dly = dly; r.tnow = tnow; r.tgt = tgt; r.utag = utag;
		r.has_exp = he; r.exp_out = eo;
		return r;
	endfunction

	initial begin
		outcome_t none;
		logic [63:0] clock_us;
		int pick;
		logic [5:0] tid;
		none = '0;
		for (int k = 0; k < NT; k++) begin
			free_ids[k] = 6'(NT - k);
			pool_live[k] = 0;
		end
		free_top = NT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty-queue errors, extremes, wraparound, unused code.
		plan.push_back(row(REQ_INTERRUPT, 0, 0, 0, 0, 1, mk(KIND_INT_DONE, 1, 0, 0, 0, 0, 1)));
		plan.push_back(row(REQ_REMOVE, 0, 0, 0, 0, 1, mk(KIND_REMOVE, 1, 0, 0, 0, 0, 1)));
		plan.push_back(row(REQ_REMOVE, 0, 0, 63, 0, 1, mk(KIND_REMOVE, 1, 63, 0, 0, 0, 1)));
		plan.push_back(row(REQ_REMOVE, 0, 0, 33, 0, 1, mk(KIND_REMOVE, 1, 33, 0, 0, 0, 1)));
		plan.push_back(row(REQ_UNUSED, '1, '1, '1, '1, 0, none));
		plan.push_back(row(REQ_REGISTER, 100, 0, 0, 32'hFFFF_FFFF, 1,
			mk(KIND_REGISTER, 0, 1, 0, 1, 100, 1)));
		plan.push_back(row(REQ_REGISTER, '1, '1, 0, 0, 0, none));
		plan.push_back(row(REQ_REGISTER, 0, '1, 0, 32'h1234_5678, 0, none));
		plan.push_back(row(REQ_REGISTER, 100, 0, 0, 5, 0, none));
		plan.push_back(row(REQ_REMOVE, 0, 0, 2, 0, 1, mk(KIND_REMOVE, 0, 2, 0, 0, 0, 1)));
		plan.push_back(row(REQ_REMOVE, 0, 0, 2, 0, 1, mk(KIND_REMOVE, 1, 2, 0, 0, 0, 1)));
		plan.push_back(row(REQ_INTERRUPT, 0, 99, 0, 0, 0, none));
		plan.push_back(row(REQ_INTERRUPT, 0, 100, 0, 0, 0, none));
		plan.push_back(row(REQ_INTERRUPT, 0, '1, 0, 0, 0, none));
		for (int k = 0; k < NT + 1; k++)
			plan.push_back(row(REQ_REGISTER, 64'(k * 3), 64'h8000_0000_0000_0000, 0,
				32'(~k), 0, none));
		plan.push_back(row(REQ_INTERRUPT, 0, '1, 0, 0, 0, none));
		foreach (plan[i]) begin
			if (plan[i].has_exp) begin
				send_request(plan[i].rq, plan[i].dly, plan[i].tnow, plan[i].tgt, plan[i].utag);
				if (pending_outcomes[$] !== plan[i].exp_out) begin
					$error("table row %0d: predictor disagrees with typed result", i);
					errors++;
				end
			end else begin
				send_request(plan[i].rq, plan[i].dly, plan[i].tnow, plan[i].tgt, plan[i].utag);
			end
		end

		// Random part: a moving clock with mostly short delays, so interrupts expire some.
		clock_us = $urandom_range(0, 1000);
		for (int n = 0; n < 280; n++) begin
			if (n > 245) quiet_end = 1;
			pick = $urandom_range(0, 99);
			clock_us = clock_us + $urandom_range(0, 40);
			if (pick < 50) begin
				send_request(REQ_REGISTER,
					($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : $urandom_range(0, 200),
					($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_us,
					6'($urandom), $urandom);
			end else if (pick < 72) begin
				live_list.delete();
				for (int k = 0; k < NT; k++) if (pool_live[k]) live_list.push_back(6'(k + 1));
				if (live_list.size() > 0 && $urandom_range(0, 3) != 0)
					tid = live_list[$urandom_range(0, live_list.size() - 1)];
				else
					tid = 6'($urandom);
				send_request(REQ_REMOVE, {$urandom, $urandom}, {$urandom, $urandom}, tid, $urandom);
			end else if (pick < 97) begin
				send_request(REQ_INTERRUPT, {$urandom, $urandom},
					($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_us,
					6'($urandom), $urandom);
			end else begin
				send_request(REQ_UNUSED, {$urandom, $urandom}, {$urandom, $urandom},
					6'($urandom), $urandom);
			end
		end
		req_valid <= 1'b0;
		quiet_end = 1;
		while (pending_outcomes.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end
endmodule

FILE: files.f
+incdir+src
src/dtq_pkg.sv
src/deadline_timer_queue_unit.sv
sim/deadline_timer_queue_unit_tb.sv
